>>> src/twg_pkg.sv
// shared types, constants and the sine table builder of the tone waveform generator
`default_nettype none

package twg_pkg;

   localparam int PERIOD_BITS_DEF  = 12;
   localparam int SINE_DEPTH_DEF   = 256;
   localparam int PERIOD_W         = 12;
   localparam int SAMPLE_W         = 16;
   localparam int AMP_W            = 15;
   localparam int TAYLOR_TERMS     = 13;

   localparam logic [AMP_W-1:0] AMP_MAX     = 15'd32767;
   localparam logic [63:0]      ONE_Q30     = 64'd1073741824;
   localparam logic [31:0]      HALF_PI_Q30 = 32'd1686629713;

   typedef enum logic [1:0] {
      WAVE_SINE     = 2'd0,
      WAVE_SQUARE   = 2'd1,
      WAVE_SAWTOOTH = 2'd2,
      WAVE_TRIANGLE = 2'd3
   } wave_mode_type;

   typedef enum logic [1:0] {
      OP_DIRECT = 2'd0,
      OP_SCALE  = 2'd1,
      OP_SINE   = 2'd2
   } op_type;

   localparam int OP_W = 2;

   // quotient bits: the larger of the amplitude and the sine table phase
   function automatic int quot_bits(input int depth);
      int a_bits;
      a_bits = $clog2(4 * depth);
      return (a_bits > AMP_W) ? a_bits : AMP_W;
   endfunction

   // trunc(32767 * sin(x)) for x in q30, evaluated at elaboration
   function automatic logic [AMP_W-1:0] sine_entry(input logic [63:0] x);
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic [63:0]        prod;
      int                 n;
      term = x;
      sum  = $signed(x);
      for (n = 1; n < TAYLOR_TERMS; n++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         case (n)
            1:       term = term / 64'd6;
            2:       term = term / 64'd20;
            3:       term = term / 64'd42;
            4:       term = term / 64'd72;
            5:       term = term / 64'd110;
            6:       term = term / 64'd156;
            7:       term = term / 64'd210;
            8:       term = term / 64'd272;
            9:       term = term / 64'd342;
            10:      term = term / 64'd420;
            11:      term = term / 64'd506;
            12:      term = term / 64'd600;
            default: term = '0;
         endcase
         if (n[0]) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum < 0) begin
         sum = '0;
      end
      if (sum > $signed(ONE_Q30)) begin
         sum = $signed(ONE_Q30);
      end
      prod = 64'(AMP_MAX) * $unsigned(sum);
      return AMP_W'(prod >> 30);
   endfunction

endpackage

`default_nettype wire

>>> src/tone_waveform_generator_unit.sv
// Tone waveform generator: one signed 16-bit sample per tick in the selected shape.
//
// Channels: req_ carries one tick (start_note, period_ticks), rsp_ returns one
// sample word per tick in order. csr_ writes the 2-bit wave mode (sine, square,
// sawtooth, triangle); csr_ready is always high and writes belong to idle time.
// The front end updates the phase counter as each tick is accepted and queues a
// divide job in a two-word queue; the back end runs a restoring divider one
// quotient bit per cycle and then looks up the sine table or scales the result.
// From accept to rsp_valid a tick passes the queue slot, the back end's load
// from IDLE, the divide steps for sine, sawtooth and triangle (QW = 15
// quotient bits at default parameters) and the SEND state; square and pause
// ticks skip the divider. The back end takes a new tick only when idle again.
// Up to two ticks are held in the queue, so req_ready stays high while the
// back end is busy until the queue fills.
// When rsp_ready is low the finished sample waits in the output register and
// the back end holds its next result until that register frees up.
// Reset clears the phase counter to 0, the wave mode to sine, empties the queue
// and drops rsp_valid. No clearing pass is needed.
`default_nettype none

module tone_waveform_generator_unit import twg_pkg::*; #(
   parameter int PERIOD_BITS      = PERIOD_BITS_DEF,
   parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output      logic                       req_ready,
   input  wire logic                       req_start_note,
   input  wire logic [PERIOD_W-1:0]        req_period_ticks,
   output      logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   output      logic signed [SAMPLE_W-1:0] rsp_sample,
   input  wire logic                       csr_valid,
   output      logic                       csr_ready,
   input  wire logic [1:0]                 csr_wave_mode
);

   localparam int QW = quot_bits(SINE_TABLE_DEPTH);
   localparam int EW = OP_W + PERIOD_BITS + QW + PERIOD_BITS;

   logic          push_valid;
   logic          push_ready;
   logic [EW-1:0] push_data;
   logic          q_valid;
   logic          q_ready;
   logic [EW-1:0] q_data;

   twg_front #(
      .PERIOD_BITS      (PERIOD_BITS),
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
      .QW               (QW),
      .EW               (EW)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_start_note   (req_start_note),
      .req_period_ticks (req_period_ticks),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_wave_mode    (csr_wave_mode),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_data        (push_data)
   );

   twg_queue #(
      .WIDTH (EW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   (push_data),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_data)
   );

   twg_back #(
      .PERIOD_BITS      (PERIOD_BITS),
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
      .QW               (QW),
      .EW               (EW)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_data     (q_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_sample (rsp_sample)
   );

endmodule

`default_nettype wire

>>> src/twg_front.sv
// front end: takes sample ticks, advances the phase and queues the divide job
`default_nettype none

module twg_front import twg_pkg::*; #(
   parameter int PERIOD_BITS      = PERIOD_BITS_DEF,
   parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF,
   parameter int QW               = quot_bits(SINE_TABLE_DEPTH),
   parameter int EW               = OP_W + 2 * PERIOD_BITS + QW
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_ready,
   input  wire logic                req_start_note,
   input  wire logic [PERIOD_W-1:0] req_period_ticks,
   input  wire logic                csr_valid,
   output      logic                csr_ready,
   input  wire logic [1:0]          csr_wave_mode,
   output      logic                push_valid,
   input  wire logic                push_ready,
   output      logic [EW-1:0]       push_data
);

   localparam int PB = PERIOD_BITS;
   localparam int NW = PB + QW;
   localparam int PW = (PB > PERIOD_W) ? PB : PERIOD_W;
   localparam logic [NW-1:0] FOUR_D = NW'(4 * SINE_TABLE_DEPTH);

   wave_mode_type   wave_mode_ff, wave_mode_in;
   logic [PB-1:0]   phase_ff, phase_in;

   logic [PW-1:0]   period_wide;
   logic [PB-1:0]   per;
   logic [PB-1:0]   half;
   logic [PB-1:0]   f_raw;
   logic [PB-1:0]   f;
   logic [PB:0]     f_inc;
   logic [PB:0]     fall_wide;
   logic [PB-1:0]   tri_x;
   logic            pause;
   logic            accept;
   op_type          op;
   logic [NW-1:0]   numer;
   logic [PB-1:0]   denom;

   assign csr_ready  = 1'b1;
   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && push_ready;

   assign period_wide = PW'(req_period_ticks);
   assign per         = period_wide[PB-1:0];
   assign half        = per >> 1;
   assign pause       = (per < PB'(2));
   assign f_raw       = req_start_note ? '0 : phase_ff;
   // a period no longer than the stored phase restarts the cycle
   assign f           = (f_raw >= per) ? '0 : f_raw;
   assign f_inc       = {1'b0, f} + (PB+1)'(1);
   assign fall_wide   = {half, 1'b0} - {1'b0, f};
   assign tri_x       = (f < half) ? f : fall_wide[PB-1:0];

   always_comb begin
      op    = OP_DIRECT;
      numer = '0;
      denom = per;
      if (!pause) begin
         case (wave_mode_ff)
            WAVE_SINE: begin
               op    = OP_SINE;
               numer = NW'(f) * FOUR_D;
            end
            WAVE_SQUARE: begin
               op    = OP_DIRECT;
               numer = (f < half) ? NW'(AMP_MAX) : '0;
            end
            WAVE_SAWTOOTH: begin
               op    = OP_SCALE;
               numer = (NW'(f) << AMP_W) - NW'(f);
            end
            WAVE_TRIANGLE: begin
               op    = OP_SCALE;
               numer = (NW'(tri_x) << AMP_W) - NW'(tri_x);
               denom = half;
            end
            default: begin
               op    = OP_DIRECT;
               numer = '0;
            end
         endcase
      end
   end

   assign push_data = {op, numer, denom};

   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         if (pause || (f_inc >= {1'b0, per})) begin
            phase_in = '0;
         end else begin
            phase_in = f_inc[PB-1:0];
         end
      end
   end

   always_comb begin
      wave_mode_in = wave_mode_ff;
      if (csr_valid) begin
         wave_mode_in = wave_mode_type'(csr_wave_mode);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         wave_mode_ff <= WAVE_SINE;
      end else begin
         phase_ff     <= phase_in;
         wave_mode_ff <= wave_mode_in;
      end
   end

endmodule

`default_nettype wire

>>> src/twg_queue.sv
// two-word queue between the front end and the divide back end
`default_nettype none

module twg_queue import twg_pkg::*; #(
   parameter int WIDTH = OP_W + 2 * PERIOD_BITS_DEF + AMP_W
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output      logic             in_ready,
   input  wire logic [WIDTH-1:0] in_data,
   output      logic             out_valid,
   input  wire logic             out_ready,
   output      logic [WIDTH-1:0] out_data
);

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push;
   logic             pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

>>> src/twg_back.sv
// back end: serial divider, sine table lookup and output register
`default_nettype none

module twg_back import twg_pkg::*; #(
   parameter int PERIOD_BITS      = PERIOD_BITS_DEF,
   parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF,
   parameter int QW               = quot_bits(SINE_TABLE_DEPTH),
   parameter int EW               = OP_W + 2 * PERIOD_BITS + QW
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       q_valid,
   output      logic                       q_ready,
   input  wire logic [EW-1:0]              q_data,
   output      logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   output      logic signed [SAMPLE_W-1:0] rsp_sample
);

   localparam int PB  = PERIOD_BITS;
   localparam int NW  = PB + QW;
   localparam int AW  = $clog2(4 * SINE_TABLE_DEPTH);
   localparam int TIW = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int CW  = $clog2(QW);
   localparam logic [AW-1:0] D1 = AW'(SINE_TABLE_DEPTH);
   localparam logic [AW-1:0] D2 = AW'(2 * SINE_TABLE_DEPTH);
   localparam logic [AW-1:0] D3 = AW'(3 * SINE_TABLE_DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_SEND = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   op_type                  op_ff, op_in;
   logic [PB-1:0]           den_ff, den_in;
   logic [PB-1:0]           rem_ff, rem_in;
   logic [QW-1:0]           quo_ff, quo_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;

   logic [AMP_W-1:0]        sine_rom [SINE_TABLE_DEPTH+1];

   op_type                  q_op;
   logic [NW-1:0]           q_numer;
   logic [PB-1:0]           q_den;
   logic [PB:0]             trial;
   logic [PB:0]             diff;
   logic                    ge;
   logic                    out_free;
   logic [AW-1:0]           a;
   logic [1:0]              quad;
   logic [AW-1:0]           base;
   logic [AW-1:0]           r;
   logic [AW-1:0]           idx_full;
   logic [TIW-1:0]          idx;
   logic signed [SAMPLE_W-1:0] sine_mag;
   logic signed [SAMPLE_W-1:0] result;

   // quarter-wave table, folded to constants at elaboration
   for (genvar gi = 0; gi <= SINE_TABLE_DEPTH; gi++) begin : g_rom
      localparam logic [63:0] ANGLE = (64'(HALF_PI_Q30) * 64'(gi)) / SINE_TABLE_DEPTH;
      assign sine_rom[gi] = sine_entry(ANGLE);
   end

   assign q_op    = op_type'(q_data[EW-1 -: OP_W]);
   assign q_numer = q_data[PB +: NW];
   assign q_den   = q_data[PB-1:0];
   assign q_ready = (state_ff == ST_IDLE);

   // one restoring step: shift in the next numerator bit, subtract if it fits
   assign trial = {rem_ff, quo_ff[QW-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = (trial >= {1'b0, den_ff});

   assign out_free = !rsp_valid_ff || rsp_ready;

   assign a = quo_ff[AW-1:0];

   always_comb begin
      if (a >= D3) begin
         quad = 2'd3;
         base = D3;
      end else if (a >= D2) begin
         quad = 2'd2;
         base = D2;
      end else if (a >= D1) begin
         quad = 2'd1;
         base = D1;
      end else begin
         quad = 2'd0;
         base = '0;
      end
   end

   assign r        = a - base;
   assign idx_full = quad[0] ? (D1 - r) : r;
   assign idx      = idx_full[TIW-1:0];
   assign sine_mag = SAMPLE_W'(sine_rom[idx]);

   always_comb begin
      case (op_ff)
         OP_SINE:   result = quad[1] ? -sine_mag : sine_mag;
         OP_SCALE:  result = SAMPLE_W'(quo_ff);
         OP_DIRECT: result = SAMPLE_W'(quo_ff);
         default:   result = '0;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      den_in        = den_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_sample_in = rsp_sample_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               op_in  = q_op;
               den_in = q_den;
               rem_in = q_numer[NW-1:QW];
               quo_in = q_numer[QW-1:0];
               cnt_in = CW'(QW - 1);
               state_in = (q_op == OP_DIRECT) ? ST_SEND : ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = ge ? diff[PB-1:0] : trial[PB-1:0];
            quo_in = {quo_ff[QW-2:0], ge};
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == '0) begin
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = result;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      den_ff        <= den_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      cnt_ff        <= cnt_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;

   // the partial remainder always stays below the divisor
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < den_ff))
      else $error("divider remainder reached the divisor");

   a_pop_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && q_valid) |=> (state_ff != ST_IDLE))
      else $error("queued word taken but back end stayed idle");

   a_send_loads_output: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEND && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished sample not moved into the output register");

endmodule

`default_nettype wire
